// ===== rtl/msrs_pkg.sv =====
// msrs_pkg: shared types and constants for the motor stall reversing sequencer
// used by msrs_cfg and motor_stall_reversing_sequencer; no dependencies
`default_nettype none

package msrs_pkg;

  // field widths
  localparam int POS_BITS   = 10;
  localparam int TIME_BITS  = 32;
  localparam int LEVEL_BITS = 8;
  localparam int THR_BITS   = 10;
  localparam int MS_BITS    = 16;
  localparam int PHASE_BITS = 2;

  // compare width for position change against threshold
  localparam int DIFF_BITS = (POS_BITS > THR_BITS) ? POS_BITS : THR_BITS;

  // stream payload widths, padded to whole bytes
  localparam int IN_BITS   = POS_BITS + TIME_BITS;
  localparam int IN_BYTES  = (IN_BITS + 7) / 8;
  localparam int IN_W      = IN_BYTES * 8;
  localparam int OUT_BITS  = 2 * LEVEL_BITS + 1 + PHASE_BITS + 1;
  localparam int OUT_BYTES = (OUT_BITS + 7) / 8;
  localparam int OUT_W     = OUT_BYTES * 8;

  // configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = MS_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_DRIVE_LEVEL   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_POT_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_STALL_TIME    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MOVE_TIME     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RECOVER_TIME  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_FAULT_HOLD    = 3'd5;

  // register reset values
  localparam logic [LEVEL_BITS-1:0] DRIVE_LEVEL_RST   = 8'd150;
  localparam logic [THR_BITS-1:0]   POT_THRESHOLD_RST = 10'd3;
  localparam logic [MS_BITS-1:0]    STALL_TIME_RST    = 16'd2000;
  localparam logic [MS_BITS-1:0]    MOVE_TIME_RST     = 16'd4000;
  localparam logic [MS_BITS-1:0]    RECOVER_TIME_RST  = 16'd1000;
  localparam logic [MS_BITS-1:0]    FAULT_HOLD_RST    = 16'd150;

  // phase codes
  localparam logic [PHASE_BITS-1:0] PH_RIGHT   = 2'd0;
  localparam logic [PHASE_BITS-1:0] PH_LEFT    = 2'd1;
  localparam logic [PHASE_BITS-1:0] PH_RECOVER = 2'd2;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] drive_level;
    logic [THR_BITS-1:0]   pot_threshold;
    logic [MS_BITS-1:0]    still_limit_ms;
    logic [MS_BITS-1:0]    move_time_ms;
    logic [MS_BITS-1:0]    recover_time_ms;
    logic [MS_BITS-1:0]    fault_hold_ms;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/msrs_cfg.sv =====
// msrs_cfg: configuration register file of the sequencer
// depends on msrs_pkg
`default_nettype none

module msrs_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [msrs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [msrs_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output msrs_pkg::cfg_t                          cfg
);
  import msrs_pkg::*;

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register writes, out-of-range indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_level     <= DRIVE_LEVEL_RST;
      cfg.pot_threshold   <= POT_THRESHOLD_RST;
      cfg.still_limit_ms  <= STALL_TIME_RST;
      cfg.move_time_ms    <= MOVE_TIME_RST;
      cfg.recover_time_ms <= RECOVER_TIME_RST;
      cfg.fault_hold_ms   <= FAULT_HOLD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DRIVE_LEVEL:   cfg.drive_level     <= cfg_data[LEVEL_BITS-1:0];
        REG_POT_THRESHOLD: cfg.pot_threshold   <= cfg_data[THR_BITS-1:0];
        REG_STALL_TIME:    cfg.still_limit_ms  <= cfg_data[MS_BITS-1:0];
        REG_MOVE_TIME:     cfg.move_time_ms    <= cfg_data[MS_BITS-1:0];
        REG_RECOVER_TIME:  cfg.recover_time_ms <= cfg_data[MS_BITS-1:0];
        REG_FAULT_HOLD:    cfg.fault_hold_ms   <= cfg_data[MS_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/motor_stall_reversing_sequencer.sv =====
// Motor stall reversing sequencer. Each input beat is one position sample with a
// millisecond timestamp and yields exactly one output beat with the drive levels,
// driver enable, phase and a stall flag. The block runs right, then left, reversing
// after move_time_ms; a position change at or below pot_threshold lasting longer than
// still_limit_ms is a stall, which starts a recovery phase (drives zero, enable low for
// fault_hold_ms) that resumes moving right after recover_time_ms. A beat passes an
// input register and an output register; one beat is taken every cycle while the output
// is free, the sequencer state being updated in the single step between the two.
// Configuration writes are to be made only while no beat is in flight.
//
// depends on msrs_pkg and msrs_cfg
`default_nettype none

module motor_stall_reversing_sequencer (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // stream in; tdata: pot_sample, now_ms
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [msrs_pkg::IN_W-1:0]          s_tdata,
  // stream out; tdata: right_drive, left_drive, driver_enable, phase, stall_event
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [msrs_pkg::OUT_W-1:0]              m_tdata,
  // configuration writes
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [msrs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [msrs_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import msrs_pkg::*;

  cfg_t cfg;

  msrs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register
  logic                 in_valid;
  logic [POS_BITS-1:0]  in_pos;
  logic [TIME_BITS-1:0] in_now;

  // output register
  logic                  out_valid;
  logic [LEVEL_BITS-1:0] out_right;
  logic [LEVEL_BITS-1:0] out_left;
  logic                  out_enable;
  logic [PHASE_BITS-1:0] out_phase;
  logic                  out_event;

  // sequencer state
  logic [PHASE_BITS-1:0] phase_reg, phase_next;
  logic [TIME_BITS-1:0]  phase_start, phase_start_next;
  logic [TIME_BITS-1:0]  still_since, still_since_next;
  logic                  still_timing, still_timing_next;
  logic [POS_BITS-1:0]   last_position, last_position_next;

  // step results
  logic [LEVEL_BITS-1:0] right_drive, left_drive;
  logic                  driver_enable, stall_event;

  logic out_free, advance;

  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // input register load
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_pos <= s_tdata[POS_BITS-1:0];
      in_now <= s_tdata[POS_BITS+TIME_BITS-1:POS_BITS];
    end
  end

  // step logic
  logic                 moving, going_right, drive_on, moved, stall;
  logic [POS_BITS-1:0]  pos_diff;
  logic [TIME_BITS-1:0] still_elapsed, phase_elapsed, hold_elapsed;

  always_comb begin
    moving        = (phase_reg == PH_RIGHT) || (phase_reg == PH_LEFT);
    going_right   = (phase_reg == PH_RIGHT);
    drive_on      = (cfg.drive_level != '0);
    pos_diff      = (in_pos > last_position) ? (in_pos - last_position)
                                             : (last_position - in_pos);
    moved         = DIFF_BITS'(pos_diff) > DIFF_BITS'(cfg.pot_threshold);
    still_elapsed = in_now - still_since;
    phase_elapsed = in_now - phase_start;
    stall         = moving && drive_on && still_timing && !moved
                    && (still_elapsed > TIME_BITS'(cfg.still_limit_ms));

    phase_next         = phase_reg;
    phase_start_next   = phase_start;
    still_since_next   = still_since;
    still_timing_next  = still_timing;
    last_position_next = last_position;
    right_drive        = '0;
    left_drive         = '0;
    stall_event        = 1'b0;

    if (moving) begin
      if (going_right) begin
        right_drive = cfg.drive_level;
      end else begin
        left_drive = cfg.drive_level;
      end
      // still timer
      if (drive_on) begin
        last_position_next = in_pos;
        if (moved || !still_timing) begin
          still_since_next  = in_now;
          still_timing_next = 1'b1;
        end
      end else begin
        still_timing_next = 1'b0;
      end
      // stall, else reversal
      if (stall) begin
        right_drive       = '0;
        left_drive        = '0;
        stall_event       = 1'b1;
        still_timing_next = 1'b0;
        phase_next        = PH_RECOVER;
        phase_start_next  = in_now;
      end else if (phase_elapsed > TIME_BITS'(cfg.move_time_ms)) begin
        right_drive       = '0;
        left_drive        = '0;
        phase_next        = going_right ? PH_LEFT : PH_RIGHT;
        phase_start_next  = in_now;
        still_timing_next = 1'b0;
      end
    end else begin
      // recovery, unused code folds in here
      phase_next = PH_RECOVER;
      if (phase_elapsed > TIME_BITS'(cfg.recover_time_ms)) begin
        phase_next        = PH_RIGHT;
        phase_start_next  = in_now;
        still_timing_next = 1'b0;
      end
    end

    hold_elapsed  = in_now - phase_start_next;
    driver_enable = !((phase_next == PH_RECOVER)
                      && (hold_elapsed < TIME_BITS'(cfg.fault_hold_ms)));
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= PH_RIGHT;
      phase_start   <= '0;
      still_since   <= '0;
      still_timing  <= 1'b0;
      last_position <= '0;
    end else if (advance) begin
      phase_reg     <= phase_next;
      phase_start   <= phase_start_next;
      still_since   <= still_since_next;
      still_timing  <= still_timing_next;
      last_position <= last_position_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_right  <= right_drive;
      out_left   <= left_drive;
      out_enable <= driver_enable;
      out_phase  <= phase_next;
      out_event  <= stall_event;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'({out_event, out_phase, out_enable, out_left, out_right});

`ifndef SYNTHESIS
  // a stall result is in recovery with both drives off
  a_stall_recover: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_event |-> out_phase == PH_RECOVER && out_right == '0
                               && out_left == '0)
    else $error("stall beat not in recovery with drives off");

  // any drive applied means a moving phase with enable released
  a_drive_enabled: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_right != '0 || out_left != '0) |->
      out_enable && out_phase != PH_RECOVER)
    else $error("drive applied while recovering or disabled");

  // never both drives at once
  a_one_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_right == '0 || out_left == '0)
    else $error("both drives active");

  // a beat leaving the input register lands in the output register
  a_advance: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("beat lost between stages");

  // entering or staying in recovery stops the still timer
  a_recover_timer: assert property (@(posedge clk) disable iff (rst)
    advance && phase_next == PH_RECOVER |=> !still_timing)
    else $error("still timer running during recovery");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// tb: self-checking bench for motor_stall_reversing_sequencer, stream in and out plus cfg writes
// holds a scoreboard class that predicts drive, enable, phase and stall flag per sample beat
// depends on msrs_pkg and the rtl of the sequencer
`default_nettype none

module tb;
  import msrs_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int RAND_PER_SETTING = 125;
  localparam int NUM_SETTINGS     = 6;
  localparam int DRAIN_CYCLES     = 4;

  // result fields, highest bit first in m_tdata
  typedef struct packed {
    logic                  stall_event;
    logic [PHASE_BITS-1:0] phase;
    logic                  driver_enable;
    logic [LEVEL_BITS-1:0] left_drive;
    logic [LEVEL_BITS-1:0] right_drive;
  } seq_result_t;

  // predictor of the sequencer plus the queue of results it still owes
  class stall_seq_scoreboard;
    logic [LEVEL_BITS-1:0] level;
    logic [THR_BITS-1:0]   thr;
    logic [MS_BITS-1:0]    stall_ms;
    logic [MS_BITS-1:0]    move_ms;
    logic [MS_BITS-1:0]    recover_ms;
    logic [MS_BITS-1:0]    hold_ms;

    logic [PHASE_BITS-1:0] phase;
    logic [TIME_BITS-1:0]  phase_start;
    logic [TIME_BITS-1:0]  still_since;
    logic                  still_timing;
    logic                  stall_seen;
    logic [POS_BITS-1:0]   last_pos;

    seq_result_t owed_q[$];
    int errors, reported, samples, stalls, reversals, resumes;

    function new();
      level        = DRIVE_LEVEL_RST;
      thr          = POT_THRESHOLD_RST;
      stall_ms     = STALL_TIME_RST;
      move_ms      = MOVE_TIME_RST;
      recover_ms   = RECOVER_TIME_RST;
      hold_ms      = FAULT_HOLD_RST;
      phase        = PH_RIGHT;
      phase_start  = '0;
      still_since  = '0;
      still_timing = 1'b0;
      stall_seen   = 1'b0;
      last_pos     = '0;
      errors = 0; reported = 0; samples = 0; stalls = 0; reversals = 0; resumes = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
      case (idx)
        REG_DRIVE_LEVEL:   level      = val[LEVEL_BITS-1:0];
        REG_POT_THRESHOLD: thr        = val[THR_BITS-1:0];
        REG_STALL_TIME:    stall_ms   = val;
        REG_MOVE_TIME:     move_ms    = val;
        REG_RECOVER_TIME:  recover_ms = val;
        REG_FAULT_HOLD:    hold_ms    = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // no-motion timer; true once still longer than the stall time
    function bit still_too_long(logic [POS_BITS-1:0] pos, logic [TIME_BITS-1:0] now);
      logic [POS_BITS-1:0]  diff;
      logic [TIME_BITS-1:0] idle_for;
      if (level == '0) begin
        still_timing = 1'b0;
        still_since  = '0;
        stall_seen   = 1'b0;
        return 1'b0;
      end
      diff     = (pos > last_pos) ? pos - last_pos : last_pos - pos;
      idle_for = now - still_since;
      if (diff > thr) begin
        still_since  = now;
        still_timing = 1'b1;
        stall_seen   = 1'b0;
      end else if (!still_timing) begin
        still_since  = now;
        still_timing = 1'b1;
      end else if (idle_for > stall_ms) begin
        stall_seen = 1'b1;
      end
      last_pos = pos;
      return stall_seen;
    endfunction

    // accepted sample beat: step the model and queue its result
    function void note_sample(logic [IN_W-1:0] tdata);
      logic [POS_BITS-1:0]  pos;
      logic [TIME_BITS-1:0] now;
      logic [TIME_BITS-1:0] in_phase;
      logic                 going_right;
      seq_result_t          res;
      pos = tdata[POS_BITS-1:0];
      now = tdata[POS_BITS +: TIME_BITS];
      res = '0;
      res.driver_enable = 1'b1;
      if (phase == PH_RIGHT || phase == PH_LEFT) begin
        going_right = (phase == PH_RIGHT);
        if (going_right) res.right_drive = level;
        else res.left_drive = level;
        if (still_too_long(pos, now)) begin
          res.right_drive = '0;
          res.left_drive  = '0;
          res.stall_event = 1'b1;
          stall_seen   = 1'b0;
          still_timing = 1'b0;
          still_since  = '0;
          phase        = PH_RECOVER;
          phase_start  = now;
          stalls++;
        end else begin
          in_phase = now - phase_start;
          if (in_phase > move_ms) begin
            res.right_drive = '0;
            res.left_drive  = '0;
            phase        = going_right ? PH_LEFT : PH_RIGHT;
            phase_start  = now;
            still_timing = 1'b0;
            still_since  = '0;
            reversals++;
          end
        end
      end else begin
        // code three folds into recovery
        phase    = PH_RECOVER;
        in_phase = now - phase_start;
        if (in_phase > recover_ms) begin
          phase        = PH_RIGHT;
          phase_start  = now;
          still_timing = 1'b0;
          still_since  = '0;
          resumes++;
        end
      end
      in_phase = now - phase_start;
      if (phase == PH_RECOVER && in_phase < hold_ms) res.driver_enable = 1'b0;
      res.phase = phase;
      owed_q.push_back(res);
      samples++;
    endfunction

    // accepted result beat: compare with the oldest owed result
    function void check_result(logic [OUT_W-1:0] tdata);
      seq_result_t got, want;
      got = seq_result_t'(tdata[OUT_BITS-1:0]);
      if (owed_q.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("unexpected result beat: r=%0d l=%0d en=%0b ph=%0d st=%0b",
                   got.right_drive, got.left_drive, got.driver_enable, got.phase,
                   got.stall_event);
        end
        return;
      end
      want = owed_q.pop_front();
      if (got.right_drive !== want.right_drive || got.left_drive !== want.left_drive ||
          got.driver_enable !== want.driver_enable || got.phase !== want.phase ||
          got.stall_event !== want.stall_event) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display({"mismatch: expected r=%0d l=%0d en=%0b ph=%0d st=%0b,",
                    " got r=%0d l=%0d en=%0b ph=%0d st=%0b"},
                   want.right_drive, want.left_drive, want.driver_enable, want.phase,
                   want.stall_event, got.right_drive, got.left_drive, got.driver_enable,
                   got.phase, got.stall_event);
        end
      end
    endfunction
  endclass

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     s_tvalid  = 1'b0;
  logic                     s_tready;
  // fields from bit 0: pot_sample, now_ms
  logic [IN_W-1:0]          s_tdata   = '0;
  logic                     m_tvalid;
  logic                     m_tready  = 1'b0;
  // fields from bit 0: right_drive, left_drive, driver_enable, phase, stall_event
  logic [OUT_W-1:0]         m_tdata;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

  stall_seq_scoreboard sb;
  int cycles        = 0;
  int send_idle_pct = 35;
  int recv_idle_pct = 71;
  int settings_run  = 0;
  int item_idx      = 0;
  int jam_left      = 0;
  int time_scale    = 2;
  int cur_pos       = 0;
  logic [TIME_BITS-1:0] cur_now = '0;

  motor_stall_reversing_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // beat monitors on both streams
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_sample(s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  task automatic send_sample(input logic [POS_BITS-1:0] pos, input logic [TIME_BITS-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W-IN_BITS){1'b0}}, now, pos};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop sending and let every owed result come back
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_valid high; caller lowers it after the last write
  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic apply_setting(input int level, input int thr, input int stall_t,
                               input int move_t, input int recover_t, input int hold_t);
    wait_idle();
    cfg_write(REG_DRIVE_LEVEL, CFG_DATA_BITS'(level));
    cfg_write(REG_POT_THRESHOLD, CFG_DATA_BITS'(thr));
    cfg_write(REG_STALL_TIME, CFG_DATA_BITS'(stall_t));
    cfg_write(REG_MOVE_TIME, CFG_DATA_BITS'(move_t));
    cfg_write(REG_RECOVER_TIME, CFG_DATA_BITS'(recover_t));
    cfg_write(REG_FAULT_HOLD, CFG_DATA_BITS'(hold_t));
    cfg_valid <= 1'b0;
    settings_run++;
    time_scale = (stall_t + move_t + recover_t) / 10 + 2;
  endtask

  // mostly a steadily advancing clock with still or moving positions, some noise
  task automatic random_sample();
    int  delta;
    bit  still;
    if ($urandom_range(99) < 12) begin
      cur_pos = $urandom_range(1023);
      cur_now = $urandom;
    end else begin
      if (jam_left == 0 && $urandom_range(99) < 10) jam_left = $urandom_range(30, 4);
      if (jam_left > 0) begin
        jam_left--;
        still = 1'b1;
      end else begin
        still = $urandom_range(1);
      end
      if (still) delta = $urandom_range(sb.thr);
      else delta = sb.thr + 1 + $urandom_range(200);
      if ($urandom_range(1)) delta = -delta;
      cur_pos = cur_pos + delta;
      if (cur_pos < 0) cur_pos = 0;
      if (cur_pos > 1023) cur_pos = 1023;
      cur_now = cur_now + $urandom_range(time_scale);
    end
    send_sample(POS_BITS'(cur_pos), cur_now);
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, stall, hold window, resume, reversal, wrap
    send_sample(10'd0, 32'd0);
    send_sample(10'd2, 32'd1000);
    send_sample(10'd3, 32'd2001);
    send_sample(10'd3, 32'd2100);
    send_sample(10'd3, 32'd2151);
    send_sample(10'd3, 32'd3001);
    send_sample(10'd3, 32'd3002);
    send_sample(10'd1023, 32'd3500);
    send_sample(10'd0, 32'd7003);
    send_sample(10'd500, 32'd8000);
    send_sample(10'd1023, 32'hFFFF_FFFF);
    send_sample(10'd600, 32'h0000_0010);

    // zero drive level: no stall timing, reversal still runs
    wait_idle();
    cfg_write(REG_DRIVE_LEVEL, 16'd0);
    cfg_valid <= 1'b0;
    send_sample(10'd600, 32'd100000);
    send_sample(10'd600, 32'd100001);
    send_sample(10'd600, 32'd200000);

    // zero fault hold and stall time, full threshold: first still beat then stall
    wait_idle();
    cfg_write(REG_DRIVE_LEVEL, 16'd255);
    cfg_write(REG_POT_THRESHOLD, 16'd1023);
    cfg_write(REG_STALL_TIME, 16'd0);
    cfg_write(REG_FAULT_HOLD, 16'd0);
    cfg_valid <= 1'b0;
    send_sample(10'd0, 32'd200002);
    send_sample(10'd1023, 32'd200003);
    send_sample(10'd1023, 32'd200003);
    send_sample(10'd1023, 32'd200004);
    cur_now = 32'd200004;

    // random phases, one per setting
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      case (s)
        0: apply_setting(150, 3, 2000, 4000, 1000, 150);
        1: apply_setting(255, 0, 0, 0, 0, 0);
        2: apply_setting(255, 1023, 65535, 65535, 65535, 65535);
        3: apply_setting(0, 5, 100, 300, 200, 50);
        default: apply_setting($urandom_range(255), $urandom_range(20), $urandom_range(400),
                               $urandom_range(800), $urandom_range(400),
                               $urandom_range(400));
      endcase
      // one setting crosses the timestamp wrap with ordinary steps
      if (s == 4) cur_now = 32'hFFFF_FFFF - TIME_BITS'(time_scale * 20);
      for (int i = 0; i < RAND_PER_SETTING; i++) begin
        if (item_idx < NUM_SETTINGS * RAND_PER_SETTING / 3) begin
          send_idle_pct = 35;
          recv_idle_pct = 71;
        end else if (item_idx < 2 * NUM_SETTINGS * RAND_PER_SETTING / 3) begin
          send_idle_pct = 71;
          recv_idle_pct = 35;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        if ($urandom_range(79) == 0) wait_idle();
        random_sample();
        item_idx++;
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    sb.errors += sb.pending();

    $display("%0d sample beats over %0d settings: %0d stalls, %0d reversals, %0d resumes",
             sb.samples, settings_run, sb.stalls, sb.reversals, sb.resumes);
    $display("%0d result errors", sb.errors);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/msrs_pkg.sv
rtl/msrs_cfg.sv
rtl/motor_stall_reversing_sequencer.sv
dv/tb.sv
